// ===== hw/rtl/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants for the line rasteriser: command codes, default
// sizes and the queue status bundle.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int COLOR_BITS      = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hw/rtl/lr_front.sv =====
// ----------------------------------------------------------------------------
// lr_front
// Classify each request and, for a load, work out the deltas, step signs,
// major axis and whether the line has any pixels at all.
// ----------------------------------------------------------------------------
module lr_front #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  lr_pkg::t_opcode        i_opcode,
    input  logic [COORD_BITS-1:0]  i_start_x,
    input  logic [COORD_BITS-1:0]  i_start_y,
    input  logic [COORD_BITS-1:0]  i_end_x,
    input  logic [COORD_BITS-1:0]  i_end_y,
    output logic                   o_is_load,
    output logic [COORD_BITS-1:0]  o_abs_dx,
    output logic [COORD_BITS-1:0]  o_abs_dy,
    output logic                   o_neg_x,
    output logic                   o_neg_y,
    output logic                   o_x_major,
    output logic                   o_busy
);
    import lr_pkg::*;

    logic [COORD_BITS:0] dx;
    logic [COORD_BITS:0] dy;
    logic [COORD_BITS:0] adx;
    logic [COORD_BITS:0] ady;

    always_comb begin
        dx  = {i_end_x[COORD_BITS-1], i_end_x} - {i_start_x[COORD_BITS-1], i_start_x};
        dy  = {i_end_y[COORD_BITS-1], i_end_y} - {i_start_y[COORD_BITS-1], i_start_y};
        adx = dx[COORD_BITS] ? (~dx + (COORD_BITS+1)'(1)) : dx;
        ady = dy[COORD_BITS] ? (~dy + (COORD_BITS+1)'(1)) : dy;
    end

    assign o_is_load = (i_opcode == OP_LOAD);
    assign o_abs_dx  = adx[COORD_BITS-1:0];
    assign o_abs_dy  = ady[COORD_BITS-1:0];
    // step negative unless the end lies strictly above the start
    assign o_neg_x   = dx[COORD_BITS] | (dx == '0);
    assign o_neg_y   = dy[COORD_BITS] | (dy == '0);
    assign o_x_major = (o_abs_dx > o_abs_dy);
    assign o_busy    = o_x_major ? (|o_abs_dx) : (|o_abs_dy);

endmodule

// ===== hw/rtl/lr_queue.sv =====
// ----------------------------------------------------------------------------
// lr_queue
// Small register FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module lr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_rdata,
    output lr_pkg::t_q_stat   o_stat
);
    import lr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== hw/rtl/lr_back.sv =====
// ----------------------------------------------------------------------------
// lr_back
// Bresenham stepper: take commands from the queue, hold the line state,
// advance one pixel per tick and present results in an output register.
// ----------------------------------------------------------------------------
module lr_back #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic                          i_is_load,
    input  logic [COORD_BITS-1:0]         i_start_x,
    input  logic [COORD_BITS-1:0]         i_start_y,
    input  logic [COORD_BITS-1:0]         i_end_x,
    input  logic [COORD_BITS-1:0]         i_end_y,
    input  logic [lr_pkg::COLOR_BITS-1:0] i_color,
    input  logic [COORD_BITS-1:0]         i_abs_dx,
    input  logic [COORD_BITS-1:0]         i_abs_dy,
    input  logic                          i_neg_x,
    input  logic                          i_neg_y,
    input  logic                          i_x_major,
    input  logic                          i_busy,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_pixel_valid,
    output logic [COORD_BITS-1:0]         o_pixel_x,
    output logic [COORD_BITS-1:0]         o_pixel_y,
    output logic [lr_pkg::COLOR_BITS-1:0] o_pixel_color,
    output logic                          o_last_pixel
);
    import lr_pkg::*;

    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 3;

    logic [C-1:0]          r_cur_x, r_cur_y, r_stop_x, r_stop_y, r_abs_dx, r_abs_dy;
    logic [E-1:0]          r_err;
    logic                  r_neg_x, r_neg_y, r_x_major, r_busy;
    logic [COLOR_BITS-1:0] r_color;

    logic                  r_out_valid, r_out_pv, r_out_last;
    logic [C-1:0]          r_out_x, r_out_y;
    logic [COLOR_BITS-1:0] r_out_color;

    logic [C-1:0] cur_maj, cur_min, stop_maj, len_maj, len_min;
    logic [C-1:0] step_maj, step_min, new_min, n_cur_x, n_cur_y;
    logic         neg_maj, neg_min, take, done, last, can_emit, tick_pop;
    logic [E-1:0] err_add, n_err, err_init;
    logic [C:0]   left;
    logic [C-1:0] init_len;

    always_comb begin
        cur_maj  = r_x_major ? r_cur_x  : r_cur_y;
        cur_min  = r_x_major ? r_cur_y  : r_cur_x;
        stop_maj = r_x_major ? r_stop_x : r_stop_y;
        neg_maj  = r_x_major ? r_neg_x  : r_neg_y;
        neg_min  = r_x_major ? r_neg_y  : r_neg_x;
        len_maj  = r_x_major ? r_abs_dx : r_abs_dy;
        len_min  = r_x_major ? r_abs_dy : r_abs_dx;

        step_maj = cur_maj + (neg_maj ? {C{1'b1}} : C'(1));
        step_min = cur_min + (neg_min ? {C{1'b1}} : C'(1));

        // error grows by twice the minor length; a minor step takes back twice the major
        err_add  = r_err + {2'b00, len_min, 1'b0};
        take     = ~err_add[E-1];
        n_err    = take ? (err_add - {2'b00, len_maj, 1'b0}) : err_add;
        new_min  = take ? step_min : cur_min;

        n_cur_x  = r_x_major ? step_maj : new_min;
        n_cur_y  = r_x_major ? new_min  : step_maj;

        left     = {stop_maj[C-1], stop_maj} - {cur_maj[C-1], cur_maj};
        last     = (left == (C+1)'(1)) || (left == {(C+1){1'b1}});
        done     = (step_maj == stop_maj);

        init_len = i_x_major ? i_abs_dx : i_abs_dy;
        err_init = ~{3'b000, init_len} + E'(1);
    end

    assign can_emit = ~r_out_valid | i_ready;
    assign o_pop    = i_cmd_valid & (i_is_load | can_emit);
    assign tick_pop = o_pop & ~i_is_load;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_is_load) begin
                r_busy <= i_busy;
            end else if (tick_pop && r_busy && done) begin
                r_busy <= 1'b0;
            end
            if (tick_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // line state and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_is_load) begin
            r_cur_x   <= i_start_x;
            r_cur_y   <= i_start_y;
            r_stop_x  <= i_end_x;
            r_stop_y  <= i_end_y;
            r_abs_dx  <= i_abs_dx;
            r_abs_dy  <= i_abs_dy;
            r_neg_x   <= i_neg_x;
            r_neg_y   <= i_neg_y;
            r_x_major <= i_x_major;
            r_err     <= err_init;
            r_color   <= i_color;
        end else if (tick_pop && r_busy) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_err   <= n_err;
        end
        if (tick_pop) begin
            r_out_pv    <= r_busy;
            r_out_x     <= r_busy ? r_cur_x : '0;
            r_out_y     <= r_busy ? r_cur_y : '0;
            r_out_color <= r_busy ? r_color : '0;
            r_out_last  <= r_busy & last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_valid = r_out_pv;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

endmodule

// ===== hw/rtl/line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// line_rasterizer
// Integer Bresenham line generator: a load request sets up a line, each tick
// request returns the next pixel along it.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s         in         i_s_tvalid/o_s_tready   tdata: coords+colour, tuser: opcode
//  m         out        o_m_tvalid/i_m_tready   tdata: pixel+colour, tuser: valid, tlast
//
//  One request per clock sustained while the output is ready: a tick popped
//  from the queue head is registered into the output register, one add-and-compare step per pixel.
//  Reset clears the queue, the busy flag and the output valid flag.
//  A stalled output holds the back end; the queue absorbs up to QUEUE_DEPTH
//  requests before o_s_tready drops. Loads produce no result.
// ----------------------------------------------------------------------------
module line_rasterizer #(
    parameter int COORD_BITS  = lr_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // start_x, start_y, end_x, end_y, color_in, zero padding
    input  logic [((4*COORD_BITS + lr_pkg::COLOR_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // opcode
    input  logic i_s_tuser,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // pixel_x, pixel_y, pixel_color, zero padding
    output logic [((2*COORD_BITS + lr_pkg::COLOR_BITS + 7) / 8) * 8 - 1:0] o_m_tdata,
    // pixel_valid
    output logic o_m_tuser,
    // last_pixel
    output logic o_m_tlast
);
    import lr_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int OUT_W  = ((2*C + COLOR_BITS + 7) / 8) * 8;
    // queue entry: load flag, start, end, colour, |dx|, |dy|, signs, major, busy
    localparam int CMD_W  = 1 + 6*C + COLOR_BITS + 4;

    t_opcode               opcode;
    logic [C-1:0]          start_x, start_y, end_x, end_y;
    logic [COLOR_BITS-1:0] color_in;

    logic                  f_is_load, f_neg_x, f_neg_y, f_x_major, f_busy;
    logic [C-1:0]          f_abs_dx, f_abs_dy;

    logic [CMD_W-1:0]      q_wdata, q_rdata;
    t_q_stat               q_stat;
    logic                  push, pop;

    logic                  b_is_load, b_neg_x, b_neg_y, b_x_major, b_busy;
    logic [C-1:0]          b_start_x, b_start_y, b_end_x, b_end_y, b_abs_dx, b_abs_dy;
    logic [COLOR_BITS-1:0] b_color;

    logic [C-1:0]          pix_x, pix_y;
    logic [COLOR_BITS-1:0] pix_color;

    // unpack the request
    assign opcode   = t_opcode'(i_s_tuser);
    assign start_x  = i_s_tdata[C-1:0];
    assign start_y  = i_s_tdata[2*C-1:C];
    assign end_x    = i_s_tdata[3*C-1:2*C];
    assign end_y    = i_s_tdata[4*C-1:3*C];
    assign color_in = i_s_tdata[4*C+COLOR_BITS-1:4*C];

    // front end: classify and set up the line
    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_opcode  (opcode),
        .i_start_x (start_x),
        .i_start_y (start_y),
        .i_end_x   (end_x),
        .i_end_y   (end_y),
        .o_is_load (f_is_load),
        .o_abs_dx  (f_abs_dx),
        .o_abs_dy  (f_abs_dy),
        .o_neg_x   (f_neg_x),
        .o_neg_y   (f_neg_y),
        .o_x_major (f_x_major),
        .o_busy    (f_busy)
    );

    // accept whenever the queue has room; the back end drains it independently
    assign o_s_tready = ~q_stat.full;
    assign push       = i_s_tvalid & o_s_tready;

    assign q_wdata = {f_is_load, start_x, start_y, end_x, end_y, color_in,
                      f_abs_dx, f_abs_dy, f_neg_x, f_neg_y, f_x_major, f_busy};

    lr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (q_wdata),
        .i_pop   (pop),
        .o_rdata (q_rdata),
        .o_stat  (q_stat)
    );

    assign {b_is_load, b_start_x, b_start_y, b_end_x, b_end_y, b_color,
            b_abs_dx, b_abs_dy, b_neg_x, b_neg_y, b_x_major, b_busy} = q_rdata;

    // back end: step the line, one pixel per tick
    lr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (~q_stat.empty),
        .i_is_load     (b_is_load),
        .i_start_x     (b_start_x),
        .i_start_y     (b_start_y),
        .i_end_x       (b_end_x),
        .i_end_y       (b_end_y),
        .i_color       (b_color),
        .i_abs_dx      (b_abs_dx),
        .i_abs_dy      (b_abs_dy),
        .i_neg_x       (b_neg_x),
        .i_neg_y       (b_neg_y),
        .i_x_major     (b_x_major),
        .i_busy        (b_busy),
        .o_pop         (pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_pixel_valid (o_m_tuser),
        .o_pixel_x     (pix_x),
        .o_pixel_y     (pix_y),
        .o_pixel_color (pix_color),
        .o_last_pixel  (o_m_tlast)
    );

    // pack the result, padding with zeros to whole bytes
    assign o_m_tdata = OUT_W'({pix_color, pix_y, pix_x});

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for line_rasterizer. A short table of hand-picked load
// and tick requests comes first, then random lines of mostly short and a few
// long spans, broken sequences and stray ticks. Each accepted request runs
// through an in-bench Bresenham tracker; the pixels it predicts are queued and
// compared field by field with what leaves the master side. Both sides pause
// at random, and the receiver stalls once for a long stretch so that the
// request queue fills and back-pressure reaches the slave side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lr_pkg::*;

    localparam int CW       = COORD_BITS_DEF;
    localparam int SD_W     = ((4*CW + COLOR_BITS + 7) / 8) * 8;
    localparam int MD_W     = ((2*CW + COLOR_BITS + 7) / 8) * 8;
    localparam int CMIN     = -(2 ** (CW-1));
    localparam int CMAX     = 2 ** (CW-1) - 1;
    localparam int N_RANDOM = 1250;  // random requests after the table
    localparam int HOLD_OFF = 120;   // one long receiver stall, in cycles
    localparam int WATCHDOG = 1000;  // cycles with no handshake on either side
    localparam int DRAIN    = 8;     // margin for stray results after the last owed pixel

    // One result as it leaves the block.
    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [COLOR_BITS-1:0] colour;
        logic                 last;
    } t_pixel;

    // One row of the directed table; typed rows carry a hand-written pixel.
    typedef struct {
        t_opcode          op;
        int               sx, sy, ex, ey;
        logic [COLOR_BITS-1:0] colour;
        bit               typed;
        t_pixel           px;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [SD_W-1:0]   i_s_tdata;   // start_x, start_y, end_x, end_y, color_in
    logic              i_s_tuser;   // opcode
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [MD_W-1:0]   o_m_tdata;   // pixel_x, pixel_y, pixel_color
    logic              o_m_tuser;   // pixel_valid
    logic              o_m_tlast;   // last_pixel

    line_rasterizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // ------------------------------------------------------------------
    // Line tracker state: the bench's own copy of the current line
    // ------------------------------------------------------------------
    int                  ln_x, ln_y, ln_stop_x, ln_stop_y;
    int                  ln_adx, ln_ady, ln_err;
    bit                  ln_neg_x, ln_neg_y, ln_x_major, ln_busy;
    logic [COLOR_BITS-1:0] ln_colour;

    t_row   plan[$];        // directed table
    t_pixel pending_px[$];  // pixels still owed by the block, oldest first

    int  errors;
    int  n_loads, n_ticks, n_pixels, n_idle_res;
    int  stalled;
    bit  calm;              // when set, neither side takes random pauses
    bit  hold_done;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Gap length for either side: mostly none, a few short, rarely long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 2 ** CW - 1)) + CMIN;
    endfunction

    function automatic logic [SD_W-1:0] pack_line(input int sx, input int sy, input int ex,
                                                  input int ey, input logic [31:0] c);
        return {c, ey[CW-1:0], ex[CW-1:0], sy[CW-1:0], sx[CW-1:0]};
    endfunction

    // Tick payload is ignored by the block; fill it with noise anyway.
    function automatic logic [SD_W-1:0] tick_noise();
        logic [95:0] r;
        r = {$urandom(), $urandom(), $urandom()};
        return r[SD_W-1:0];
    endfunction

    function automatic t_pixel mk_px(input bit v, input int x, input int y,
                                     input logic [31:0] c, input bit l);
        t_pixel p;
        p.valid  = v;
        p.x      = x[CW-1:0];
        p.y      = y[CW-1:0];
        p.colour = c;
        p.last   = l;
        return p;
    endfunction

    task automatic add_row(input t_opcode op, input int sx, input int sy, input int ex,
                           input int ey, input logic [31:0] c, input bit typed,
                           input t_pixel px);
        t_row rw;
        rw.op = op;  rw.sx = sx;  rw.sy = sy;  rw.ex = ex;  rw.ey = ey;
        rw.colour = c;  rw.typed = typed;  rw.px = px;
        plan.push_back(rw);
    endtask

    // Advance the line tracker by one request; a tick always yields a pixel,
    // which is all zeros when no line is in progress.
    task automatic bresenham_step(input t_opcode op, input logic [SD_W-1:0] d,
                                  output bit emits, output t_pixel px);
        int left;
        px    = '0;
        emits = 1'b0;
        if (op == OP_LOAD) begin
            ln_x      = $signed(d[CW-1:0]);
            ln_y      = $signed(d[2*CW-1:CW]);
            ln_stop_x = $signed(d[3*CW-1:2*CW]);
            ln_stop_y = $signed(d[4*CW-1:3*CW]);
            ln_colour = d[4*CW +: COLOR_BITS];
            ln_adx    = (ln_stop_x > ln_x) ? ln_stop_x - ln_x : ln_x - ln_stop_x;
            ln_ady    = (ln_stop_y > ln_y) ? ln_stop_y - ln_y : ln_y - ln_stop_y;
            // an axis counts down unless its end lies strictly above its start
            ln_neg_x   = !(ln_stop_x > ln_x);
            ln_neg_y   = !(ln_stop_y > ln_y);
            // a tie in the deltas leaves y as the major axis
            ln_x_major = ln_adx > ln_ady;
            ln_err     = ln_x_major ? -ln_adx : -ln_ady;
            ln_busy    = ln_x_major ? (ln_adx != 0) : (ln_ady != 0);
        end else begin
            emits = 1'b1;
            if (ln_busy) begin
                px = mk_px(1'b1, ln_x, ln_y, ln_colour, 1'b0);
                left = ln_x_major ? ln_stop_x - ln_x : ln_stop_y - ln_y;
                px.last = (left == 1) || (left == -1);
                if (ln_x_major) begin
                    ln_err += 2 * ln_ady;
                    if (ln_err >= 0) begin
                        ln_y   += ln_neg_y ? -1 : 1;
                        ln_err -= 2 * ln_adx;
                    end
                    ln_x += ln_neg_x ? -1 : 1;
                    if (ln_x == ln_stop_x) ln_busy = 1'b0;
                end else begin
                    ln_err += 2 * ln_adx;
                    if (ln_err >= 0) begin
                        ln_x   += ln_neg_x ? -1 : 1;
                        ln_err -= 2 * ln_ady;
                    end
                    ln_y += ln_neg_y ? -1 : 1;
                    if (ln_y == ln_stop_y) ln_busy = 1'b0;
                end
            end
        end
    endtask

    // Offer one request after a random gap and hold it until accepted; then
    // queue the pixel it owes, the typed one where the table gives it.
    task automatic send_req(input t_opcode op, input logic [SD_W-1:0] d,
                            input bit typed, input t_pixel typed_px);
        bit     emits;
        t_pixel px;
        int     gap;
        gap = gap_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        bresenham_step(op, d, emits, px);
        if (emits) pending_px.push_back(typed ? typed_px : px);
        if (op == OP_LOAD) n_loads++;
        else n_ticks++;
    endtask

    task automatic report(input string field, input longint got, input longint want);
        $display("mismatch on %s: got %0h, want %0h (result %0d, t=%0t)",
                 field, got, want, n_pixels + n_idle_res, $time);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, one long hold-off once traffic flows
    // ------------------------------------------------------------------
    initial begin : receiver
        int g;
        i_m_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        forever begin
            if (!hold_done && n_pixels >= 300) begin
                // hold the output long enough for the request queue to fill
                hold_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end else begin
                g = gap_len();
                if (g > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: compare each accepted result with the oldest pixel owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_pixel want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_px.size() == 0) begin
                report("unexpected result", o_m_tdata, 0);
            end else begin
                want = pending_px.pop_front();
                if (o_m_tuser !== want.valid)
                    report("pixel_valid", o_m_tuser, want.valid);
                if (o_m_tdata[CW-1:0] !== want.x)
                    report("pixel_x", o_m_tdata[CW-1:0], want.x);
                if (o_m_tdata[2*CW-1:CW] !== want.y)
                    report("pixel_y", o_m_tdata[2*CW-1:CW], want.y);
                if (o_m_tdata[2*CW +: COLOR_BITS] !== want.colour)
                    report("pixel_color", o_m_tdata[2*CW +: COLOR_BITS], want.colour);
                if (o_m_tlast !== want.last)
                    report("last_pixel", o_m_tlast, want.last);
            end
            if (o_m_tuser === 1'b1) n_pixels++;
            else n_idle_res++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: drop the run if no handshake happens on either side for long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                stalled <= 0;
            end else if (stalled + 1 >= WATCHDOG) begin
                $display("no handshake for %0d cycles at t=%0t", WATCHDOG, $time);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                stalled <= stalled + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_pixel idle_px;
        int     pick, r, span, dx, dy, sx, sy, ex, ey, n;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = OP_LOAD;
        errors     = 0;
        stalled    = 0;
        calm       = 1'b0;
        hold_done  = 1'b0;
        n_loads = 0;  n_ticks = 0;  n_pixels = 0;  n_idle_res = 0;
        ln_x = 0;  ln_y = 0;  ln_stop_x = 0;  ln_stop_y = 0;
        ln_adx = 0;  ln_ady = 0;  ln_err = 0;
        ln_neg_x = 0;  ln_neg_y = 0;  ln_x_major = 0;  ln_busy = 0;  ln_colour = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_px = mk_px(1'b0, 0, 0, 32'h0, 1'b0);

        // tick straight out of reset: nothing to draw
        add_row(OP_TICK, 0, 0, 0, 0, 32'h0, 1'b1, idle_px);
        // start equals end: the line is empty, the block stays idle
        add_row(OP_LOAD, 3, 3, 3, 3, 32'hFFFF_FFFF, 1'b0, idle_px);
        add_row(OP_TICK, 0, 0, 0, 0, 32'h0, 1'b1, idle_px);
        // one-pixel line: the start point is also the last pixel
        add_row(OP_LOAD, 0, 0, 1, 0, 32'h1234_5678, 1'b0, idle_px);
        add_row(OP_TICK, 0, 0, 0, 0, 32'h0, 1'b1, mk_px(1'b1, 0, 0, 32'h1234_5678, 1'b1));
        add_row(OP_TICK, 0, 0, 0, 0, 32'h0, 1'b1, idle_px);
        // corner to corner, equal deltas so y leads
        add_row(OP_LOAD, CMIN, CMIN, CMAX, CMAX, 32'h0, 1'b0, idle_px);
        add_row(OP_TICK, 0, 0, 0, 0, 32'h0, 1'b1, mk_px(1'b1, CMIN, CMIN, 32'h0, 1'b0));
        add_row(OP_TICK, 0, 0, 0, 0, 32'h0, 1'b0, idle_px);
        add_row(OP_TICK, 0, 0, 0, 0, 32'h0, 1'b0, idle_px);
        // new line while the previous one is still being drawn
        add_row(OP_LOAD, CMAX, CMIN, CMIN, CMAX, 32'hFFFF_FFFF, 1'b0, idle_px);
        add_row(OP_TICK, 0, 0, 0, 0, 32'h0, 1'b1,
                mk_px(1'b1, CMAX, CMIN, 32'hFFFF_FFFF, 1'b0));
        add_row(OP_TICK, 0, 0, 0, 0, 32'h0, 1'b0, idle_px);
        // flat line running leftwards; y has no delta and counts down unused
        add_row(OP_LOAD, 5, 5, 2, 5, 32'hA5A5_A5A5, 1'b0, idle_px);
        repeat (3) add_row(OP_TICK, 0, 0, 0, 0, 32'h0, 1'b0, idle_px);
        // steep line up and to the left
        add_row(OP_LOAD, 0, 0, -3, 7, 32'h5A5A_5A5A, 1'b0, idle_px);
        repeat (7) add_row(OP_TICK, 0, 0, 0, 0, 32'h0, 1'b0, idle_px);
        add_row(OP_TICK, 0, 0, 0, 0, 32'h0, 1'b1, idle_px);

        foreach (plan[i])
            send_req(plan[i].op,
                     pack_line(plan[i].sx, plan[i].sy, plan[i].ex, plan[i].ey, plan[i].colour),
                     plan[i].typed, plan[i].px);

        // Random part: mostly whole lines ticked through to the end, some cut
        // short or overrun, plus full-range loads and stray ticks.
        while (n_loads + n_ticks < plan.size() + N_RANDOM) begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                r = $urandom_range(0, 99);
                span = (r < 80) ? $urandom_range(0, 16) :
                       (r < 97) ? $urandom_range(17, 120) : $urandom_range(200, 600);
                dx = $urandom_range(0, span);
                dy = $urandom_range(0, span);
                if ($urandom_range(0, 1)) dx = span;
                else dy = span;
                if ($urandom_range(0, 1)) dx = -dx;
                if ($urandom_range(0, 1)) dy = -dy;
                sx = rand_coord();
                sy = rand_coord();
                ex = sx + dx;
                ey = sy + dy;
                // fold back lines that would leave the coordinate range
                if (ex > CMAX || ex < CMIN) ex = sx - dx;
                if (ey > CMAX || ey < CMIN) ey = sy - dy;
                send_req(OP_LOAD, pack_line(sx, sy, ex, ey, $urandom()), 1'b0, idle_px);
                n = (span < 0) ? 0 : span;
                r = $urandom_range(0, 9);
                if (r == 0) n = $urandom_range(0, n);
                else if (r == 1) n += $urandom_range(1, 3);
                repeat (n) send_req(OP_TICK, tick_noise(), 1'b0, idle_px);
            end else if (pick < 90) begin
                send_req(OP_LOAD, tick_noise(), 1'b0, idle_px);
                repeat ($urandom_range(0, 5)) send_req(OP_TICK, tick_noise(), 1'b0, idle_px);
            end else begin
                repeat ($urandom_range(1, 3)) send_req(OP_TICK, tick_noise(), 1'b0, idle_px);
            end
        end
        calm = 1'b0;
        i_s_tvalid <= 1'b0;

        // drain: wait for every owed pixel, then watch for stray results
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("drove %0d line loads and %0d ticks, including one long output stall",
                 n_loads, n_ticks);
        $display("checked %0d plotted pixels and %0d idle tick results, %0d mismatches",
                 n_pixels, n_idle_res, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== line_rasterizer.f =====
hw/rtl/lr_pkg.sv
hw/rtl/lr_front.sv
hw/rtl/lr_queue.sv
hw/rtl/lr_back.sv
hw/rtl/line_rasterizer.sv
test/testbench.sv
